### src/bounded_set_min_max_gap_unit_assert.svh
// Assertion macros for the bounded set min/max gap unit.
// Expects signals named clk and rst in the including module.
`ifndef BOUNDED_SET_MIN_MAX_GAP_UNIT_ASSERT_SVH
`define BOUNDED_SET_MIN_MAX_GAP_UNIT_ASSERT_SVH

// Checked on every rising clk edge outside reset.
`define BSMG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define BSMG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bsmg_pkg.sv
// Package for the bounded set min/max gap unit: widths, codes and structs.
// No dependencies.
package bsmg_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SPAN_W   = 33;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DEFAULT_MAX_ENTRIES = 64;
  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

  localparam logic [SPAN_W-1:0] SPAN_NONE = '1;

  localparam logic CMD_ADD_ONE = 1'b0;
  localparam logic CMD_ADD_RUN = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RUN  = 2'd2;

  typedef struct packed {
    logic                      ins;
    logic                      has_right;
    logic signed [VALUE_W-1:0] left;
    logic signed [VALUE_W-1:0] right;
  } cell_tap_t;

  typedef struct packed {
    logic                      capture;
    logic                      has_left;
    logic                      has_right;
    logic signed [VALUE_W-1:0] left;
    logic signed [VALUE_W-1:0] right;
    logic signed [VALUE_W-1:0] value;
  } nb_t;

  typedef struct packed {
    logic                      busy;
    logic [SPAN_W-1:0]         least_gap;
    logic signed [VALUE_W-1:0] min_val;
    logic signed [VALUE_W-1:0] max_val;
  } gap_stat_t;

endpackage

### src/bounded_set_min_max_gap_unit.sv
// Bounded sorted multiset of signed 32-bit values reporting, after every item, a status,
// the least gap between sorted neighbors, max minus min and the count held. Values sit in
// a chain of MAX_ENTRIES cells that shift up to open a slot for each copy. An item that
// inserts copies runs the insert step of the cell chain, one copy per cycle, then waits
// for the gap update behind it before its result is loaded into the output register; a
// refused item or an empty run goes straight to the output register. The unit takes no
// new item until its result has been loaded. A result stalled at the output holds
// the input off until it is taken.
module bounded_set_min_max_gap_unit #(
  parameter int unsigned MAX_ENTRIES = bsmg_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsmg_pkg::COUNT_W-1:0]  cfg_data,       // capacity
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,   // value, run_begin, run_end
  input  logic [0:0]                    s_axis_tuser,   // command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [79:0]                   m_axis_tdata,   // shortest_span, longest_span,
                                                        // stored_count
  output logic [bsmg_pkg::STATUS_W-1:0] m_axis_tuser    // status
);
  import bsmg_pkg::*;
  `include "bounded_set_min_max_gap_unit_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [COUNT_W-1:0]        capacity;
  logic [COUNT_W-1:0]        cap_eff;
  logic [COUNT_W-1:0]        held_count;
  logic [COUNT_W-1:0]        copies_left;
  logic [COUNT_W-1:0]        copies_next;
  logic [STATUS_W-1:0]       status;
  logic [STATUS_W-1:0]       status_next;
  logic signed [VALUE_W-1:0] item_value;

  logic                      in_cmd;
  logic signed [VALUE_W-1:0] in_value;
  logic [COUNT_W-1:0]        in_begin;
  logic [COUNT_W-1:0]        in_end;
  logic [COUNT_W-1:0]        run_len;
  logic [COUNT_W:0]          run_sum;
  logic                      in_accept;
  logic                      shift_en;
  logic                      out_load;

  logic                      cell_le    [MAX_ENTRIES];
  logic signed [VALUE_W-1:0] cell_value [MAX_ENTRIES];
  cell_tap_t                 cell_tap   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    ins_vec;
  nb_t                       nb;
  gap_stat_t                 gstat;

  logic [SPAN_W-1:0]         shortest;
  logic [SPAN_W-1:0]         longest;

  assign in_cmd   = s_axis_tuser[0];
  assign in_value = s_axis_tdata[31:0];
  assign in_begin = s_axis_tdata[38:32];
  assign in_end   = s_axis_tdata[45:39];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign shift_en      = (state == ST_RUN) && (copies_left != '0);
  assign out_load      = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  assign cap_eff = (32'(capacity) > 32'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES) : capacity;
  assign run_len = in_end - in_begin;
  assign run_sum = {1'b0, held_count} + {1'b0, run_len};

  always_comb begin
    status_next = STATUS_OK;
    copies_next = '0;
    if (in_cmd == CMD_ADD_ONE) begin
      if (held_count < cap_eff) begin
        copies_next = COUNT_W'(1);
      end else begin
        status_next = STATUS_NO_SPACE;
      end
    end else if (in_begin > in_end) begin
      status_next = STATUS_BAD_RUN;
    end else if ((run_sum <= {1'b0, cap_eff}) && (in_end <= capacity)) begin
      copies_next = run_len;
    end else begin
      status_next = STATUS_NO_SPACE;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (copies_next != '0) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (copies_left == '0 && !gstat.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      capacity      <= CAPACITY_RESET;
      held_count    <= '0;
      copies_left   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (in_accept) begin
        copies_left <= copies_next;
      end else if (shift_en) begin
        copies_left <= copies_left - COUNT_W'(1);
      end
      if (shift_en) begin
        held_count <= held_count + COUNT_W'(1);
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_value <= in_value;
      status     <= status_next;
    end
    if (out_load) begin
      m_axis_tdata <= {7'd0, held_count, longest, shortest};
      m_axis_tuser <= status;
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      bsmg_cell #(.INDEX(i)) u_cell (
        .clk        (clk),
        .shift_en   (shift_en),
        .held_count (held_count),
        .ins_value  (item_value),
        .prev_le    (1'b1),
        .prev_value ('0),
        .le         (cell_le[i]),
        .value      (cell_value[i]),
        .tap        (cell_tap[i])
      );
    end else begin : g_body
      bsmg_cell #(.INDEX(i)) u_cell (
        .clk        (clk),
        .shift_en   (shift_en),
        .held_count (held_count),
        .ins_value  (item_value),
        .prev_le    (cell_le[i-1]),
        .prev_value (cell_value[i-1]),
        .le         (cell_le[i]),
        .value      (cell_value[i]),
        .tap        (cell_tap[i])
      );
    end
    assign ins_vec[i] = cell_tap[i].ins;
  end

  // only the insertion cell drives its taps, so an OR picks them out
  always_comb begin
    nb.capture   = shift_en;
    nb.has_left  = !cell_tap[0].ins;
    nb.has_right = 1'b0;
    nb.left      = '0;
    nb.right     = '0;
    nb.value     = item_value;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      nb.has_right = nb.has_right | cell_tap[i].has_right;
      nb.left      = nb.left | cell_tap[i].left;
      nb.right     = nb.right | cell_tap[i].right;
    end
  end

  bsmg_gap u_gap (
    .clk  (clk),
    .rst  (rst),
    .nb   (nb),
    .stat (gstat)
  );

  always_comb begin
    shortest = SPAN_NONE;
    longest  = SPAN_NONE;
    if (held_count >= COUNT_W'(2)) begin
      shortest = gstat.least_gap;
      longest  = {gstat.max_val[VALUE_W-1], gstat.max_val}
               - {gstat.min_val[VALUE_W-1], gstat.min_val};
    end
  end

  `BSMG_ASSERT(a_held_bound, 32'(held_count) <= 32'(MAX_ENTRIES), "held count above cell count")
  `BSMG_ASSERT(a_one_slot, shift_en |-> $onehot(ins_vec), "insert without a single slot")
  `BSMG_ASSERT(a_done_clean, state == ST_DONE |-> (copies_left == '0 && !gstat.busy), "result before inserts finished")
  `BSMG_ASSERT(a_gap_set, (m_axis_tvalid && m_axis_tdata[72:66] >= 7'd2) |-> m_axis_tdata[32:0] != SPAN_NONE, "missing gap with two values held")

endmodule

### src/bsmg_cell.sv
// One cell of the sorted insertion chain: holds one value, shifts up on insert.
// Depends on bsmg_pkg.
module bsmg_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                               clk,
  input  logic                               shift_en,
  input  logic [bsmg_pkg::COUNT_W-1:0]       held_count,
  input  logic signed [bsmg_pkg::VALUE_W-1:0] ins_value,
  input  logic                               prev_le,
  input  logic signed [bsmg_pkg::VALUE_W-1:0] prev_value,
  output logic                               le,
  output logic signed [bsmg_pkg::VALUE_W-1:0] value,
  output bsmg_pkg::cell_tap_t                tap
);
  import bsmg_pkg::*;

  logic        valid;
  logic        ins;
  logic [31:0] held_wide;

  assign held_wide = 32'(held_count);
  assign valid     = held_wide > 32'(INDEX);
  assign le        = valid && (value <= ins_value);
  // first cell whose value is above the new one (or empty) takes it
  assign ins       = !le && prev_le;

  always_ff @(posedge clk) begin
    if (shift_en && !le) begin
      value <= prev_le ? ins_value : prev_value;
    end
  end

  assign tap.ins       = ins;
  assign tap.has_right = ins && valid;
  assign tap.left      = ins ? prev_value : '0;
  assign tap.right     = (ins && valid) ? value : '0;

endmodule

### src/bsmg_gap.sv
// Least neighbor gap and min/max tracking, updated from the insert neighbors.
// Depends on bsmg_pkg.
module bsmg_gap (
  input  logic                clk,
  input  logic                rst,
  input  bsmg_pkg::nb_t       nb,
  output bsmg_pkg::gap_stat_t stat
);
  import bsmg_pkg::*;

  logic                      pend;
  logic                      has_left;
  logic                      has_right;
  logic signed [VALUE_W-1:0] left;
  logic signed [VALUE_W-1:0] right;
  logic signed [VALUE_W-1:0] value;
  logic [SPAN_W-1:0]         least_gap;
  logic [SPAN_W-1:0]         least_gap_next;
  logic [SPAN_W-1:0]         gap_lo;
  logic [SPAN_W-1:0]         gap_hi;
  logic signed [VALUE_W-1:0] min_val;
  logic signed [VALUE_W-1:0] max_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      least_gap <= SPAN_NONE;
    end else begin
      pend <= nb.capture;
      if (pend) begin
        least_gap <= least_gap_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nb.capture) begin
      has_left  <= nb.has_left;
      has_right <= nb.has_right;
      left      <= nb.left;
      right     <= nb.right;
      value     <= nb.value;
      if (!nb.has_left) begin
        min_val <= nb.value;
      end
      if (!nb.has_right) begin
        max_val <= nb.value;
      end
    end
  end

  // inserting between a and b: new gaps never exceed the old b - a
  always_comb begin
    gap_lo = has_left  ? ({value[VALUE_W-1], value} - {left[VALUE_W-1], left})   : SPAN_NONE;
    gap_hi = has_right ? ({right[VALUE_W-1], right} - {value[VALUE_W-1], value}) : SPAN_NONE;
    least_gap_next = least_gap;
    if (gap_lo < least_gap_next) begin
      least_gap_next = gap_lo;
    end
    if (gap_hi < least_gap_next) begin
      least_gap_next = gap_hi;
    end
  end

  assign stat.busy      = pend;
  assign stat.least_gap = least_gap;
  assign stat.min_val   = min_val;
  assign stat.max_val   = max_val;

endmodule

### sim/tb_bounded_set_min_max_gap_unit.sv
// Testbench for bounded_set_min_max_gap_unit: streams add-one and add-run items
// and checks status, shortest/longest span and count against an in-bench predictor.
// Depends on bsmg_pkg and the bounded_set_min_max_gap_unit RTL.
`timescale 1ns / 100ps

module tb_bounded_set_min_max_gap_unit;
  import bsmg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 250;
  localparam int END_WAIT    = 80;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        run_begin;
    logic [COUNT_W-1:0]        run_end;
    bit                        hold;
  } set_item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SPAN_W-1:0]   shortest;
    logic [SPAN_W-1:0]   longest;
    logic [COUNT_W-1:0]  count;
  } gap_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;
  logic [0:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [79:0]          m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  set_item_t   pending_q[$];
  gap_report_t report_q[$];
  set_item_t   cur_item;
  idle_mode_t  idle_mode = IDLE_NONE;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  // predictor state
  logic signed [VALUE_W-1:0] set_vals[DEFAULT_MAX_ENTRIES];
  int                        held = 0;
  logic [COUNT_W-1:0]        cap_reg = CAPACITY_RESET;
  logic signed [VALUE_W-1:0] val_base = '0;

  bounded_set_min_max_gap_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic gap_report_t predict_report(set_item_t it);
    gap_report_t r;
    int          eff;
    int          n;
    int          pos;
    longint      d;
    longint      least;
    longint      widest;
    eff = (cap_reg > DEFAULT_MAX_ENTRIES) ? DEFAULT_MAX_ENTRIES : int'(cap_reg);
    r.status = STATUS_OK;
    n = 0;
    if (it.cmd == CMD_ADD_ONE) begin
      if (held < eff) n = 1;
      else r.status = STATUS_NO_SPACE;
    end else if (it.run_begin > it.run_end) begin
      r.status = STATUS_BAD_RUN;
    end else begin
      n = int'(it.run_end) - int'(it.run_begin);
      if (!(held + n <= eff && it.run_end <= cap_reg)) begin
        r.status = STATUS_NO_SPACE;
        n = 0;
      end
    end
    if (n > 0) begin
      pos = 0;
      while (pos < held && set_vals[pos] <= it.value) pos++;
      for (int i = held - 1; i >= pos; i--) set_vals[i + n] = set_vals[i];
      for (int i = 0; i < n; i++) set_vals[pos + i] = it.value;
      held += n;
    end
    if (held >= 2) begin
      least = longint'(set_vals[1]) - longint'(set_vals[0]);
      for (int i = 1; i + 1 < held; i++) begin
        d = longint'(set_vals[i + 1]) - longint'(set_vals[i]);
        if (d < least) least = d;
      end
      widest = longint'(set_vals[held - 1]) - longint'(set_vals[0]);
      r.shortest = least[SPAN_W-1:0];
      r.longest  = widest[SPAN_W-1:0];
    end else begin
      r.shortest = SPAN_NONE;
      r.longest  = SPAN_NONE;
    end
    r.count = held[COUNT_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    bit          busy;
    gap_report_t rep;
    if (!rst) begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        rep = predict_report(cur_item);
        report_q = {report_q, rep};
        busy = 1'b0;
      end
      if (!busy && pending_q.size() > 0) begin
        if (!(pending_q[0].hold && report_q.size() != 0) &&
            !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 82) ||
              (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 21))) begin
          cur_item = pending_q.pop_front();
          s_axis_tdata <= {2'b00, cur_item.run_end, cur_item.run_begin, cur_item.value};
          s_axis_tuser <= cur_item.cmd;
          busy = 1'b1;
        end
      end
      s_axis_tvalid <= busy;
    end
  end

  // monitor
  always @(posedge clk) begin
    gap_report_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (report_q.size() == 0) begin
          $error("unexpected result: status %0d count %0d", m_axis_tuser, m_axis_tdata[72:66]);
          err_cnt++;
        end else begin
          want = report_q.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[32:0] !== want.shortest) begin
            $error("shortest_span: expected %h, got %h", want.shortest, m_axis_tdata[32:0]);
            err_cnt++;
          end
          if (m_axis_tdata[65:33] !== want.longest) begin
            $error("longest_span: expected %h, got %h", want.longest, m_axis_tdata[65:33]);
            err_cnt++;
          end
          if (m_axis_tdata[72:66] !== want.count) begin
            $error("stored_count: expected %0d, got %0d", want.count, m_axis_tdata[72:66]);
            err_cnt++;
          end
        end
      end
      case (idle_mode)
        IDLE_RECV: m_axis_tready <= ($urandom_range(0, 99) >= 82);
        IDLE_BOTH: m_axis_tready <= ($urandom_range(0, 99) >= 21);
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  function automatic set_item_t mk_item(logic cmd, logic signed [VALUE_W-1:0] v,
                                        int b, int e);
    set_item_t it;
    it.cmd       = cmd;
    it.value     = v;
    it.run_begin = b[COUNT_W-1:0];
    it.run_end   = e[COUNT_W-1:0];
    it.hold      = 1'b0;
    return it;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      4, 5, 6: return val_base + $signed(32'($urandom_range(0, 40)) - 32'sd20);
      default: return $urandom;
    endcase
  endfunction

  function automatic set_item_t random_item();
    set_item_t it;
    int        r;
    int        n;
    int        b;
    int        e;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      it = mk_item(CMD_ADD_ONE, pick_value(), $urandom_range(0, 127), $urandom_range(0, 127));
    end else if (r < 80) begin
      n = $urandom_range(0, 3);
      e = (int'(cap_reg) < n) ? n : $urandom_range(n, int'(cap_reg));
      it = mk_item(CMD_ADD_RUN, pick_value(), e - n, e);
    end else if (r < 90) begin
      b = $urandom_range(1, 127);
      it = mk_item(CMD_ADD_RUN, pick_value(), b, $urandom_range(0, b - 1));
    end else begin
      it = mk_item(1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 127),
                   $urandom_range(0, 127));
    end
    return it;
  endfunction

  task automatic enqueue(set_item_t it);
    pending_q = {pending_q, it};
  endtask

  task automatic write_capacity(logic [COUNT_W-1:0] c);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = c;
  endtask

  // sampled mid-cycle so the driver and monitor have settled
  task automatic wait_drained();
    do @(negedge clk); while (pending_q.size() != 0 || s_axis_tvalid || report_q.size() != 0);
  endtask

  initial begin
    logic [COUNT_W-1:0] caps[7];
    set_item_t          it;
    caps = '{7'd0, 7'd16, 7'd30, 7'd48, 7'd64, 7'd127, 7'd5};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_capacity(7'd8);
    enqueue(mk_item(CMD_ADD_ONE, 32'sd5, 0, 0));
    enqueue(mk_item(CMD_ADD_ONE, 32'sh8000_0000, 127, 127));
    enqueue(mk_item(CMD_ADD_ONE, 32'sh7fff_ffff, 64, 0));
    enqueue(mk_item(CMD_ADD_RUN, 32'sd9, 3, 3));      // empty run
    enqueue(mk_item(CMD_ADD_RUN, 32'sd1, 127, 0));    // begin above end
    enqueue(mk_item(CMD_ADD_RUN, 32'sd1, 0, 9));      // end above capacity
    enqueue(mk_item(CMD_ADD_RUN, 32'sd5, 5, 7));      // duplicates, gap 0
    enqueue(mk_item(CMD_ADD_RUN, 32'sd2, 64, 64));    // empty run past capacity
    enqueue(mk_item(CMD_ADD_RUN, 32'sd2, 0, 8));      // overflow
    enqueue(mk_item(CMD_ADD_ONE, -32'sd1, 0, 0));
    enqueue(mk_item(CMD_ADD_RUN, 32'sh8000_0000, 6, 8));
    enqueue(mk_item(CMD_ADD_ONE, 32'sd0, 0, 0));      // full
    enqueue(mk_item(CMD_ADD_RUN, 32'sd0, 0, 0));      // empty run when full
    enqueue(mk_item(CMD_ADD_ONE, 32'sh7fff_ffff, 0, 0));
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_capacity(caps[p]);
      idle_mode = idle_mode_t'((p + 1) % 4);
      val_base  = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it = random_item();
        if (p == 2 && k == 100) it.hold = 1'b1;
        enqueue(it);
      end
      wait_drained();
    end

    idle_mode = IDLE_NONE;
    repeat (END_WAIT) @(posedge clk);
    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
